[src/mpoa_pkg.sv]
// Package for the Matsubara phase outer accumulator: word types, constants,
// command structs and CORDIC arctangent table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mpoa_pkg;

    localparam int NumOrbitals = 4;
    localparam int NumFreq     = 32;
    localparam int OrbW        = 2;
    localparam int FreqW       = 5;
    localparam int AddrW       = 2 * OrbW + 2 * FreqW;
    localparam int Depth       = 1 << AddrW;
    localparam int CordicSteps = 30;
    localparam int StepW       = 5;

    localparam logic signed [47:0] AccMax = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] AccMin = 48'sh8000_0000_0000;
    localparam logic signed [32:0] One30  = 33'sd1073741824;
    localparam logic signed [32:0] CordicX0 = 33'sd652032874;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_ACCUM = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        CFG_INV_BETA  = 2'd0,
        CFG_FIRST_ROW = 2'd1,
        CFG_FIRST_COL = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [31:0]        time_row;
        logic [31:0]        time_col;
        logic [1:0]         orbital_row;
        logic [1:0]         orbital_col;
        logic signed [31:0] weight_re;
        logic signed [31:0] weight_im;
        logic [4:0]         freq_row;
        logic [4:0]         freq_col;
    } in_word_t;

    typedef struct packed {
        logic signed [47:0] value_re;
        logic signed [47:0] value_im;
        logic               saturated_flag;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_ANGLE,
        ST_CORDIC_START,
        ST_CORDIC_RUN,
        ST_WEIGHT,
        ST_MAC,
        ST_READ,
        ST_READ_WAIT,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_req;
        logic clear_wr;
        logic angle_mul;
        logic cordic_start;
        logic cordic_step;
        logic cordic_store;
        logic weight_mul;
        logic mac_rd;
        logic mac_wr;
        logic read_rd;
        logic out_load;
        logic [AddrW-1:0] addr;
        logic [FreqW:0]   idx;
        logic             col_sel;
        logic [StepW-1:0] step;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] req_type;
        logic       orb_ok;
        logic       read_ok;
        logic [OrbW-1:0] orow;
        logic [OrbW-1:0] ocol;
    } status_t;

    function automatic logic [31:0] atan_turns(input logic [StepW-1:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[src/mpoa_cordic.sv]
// Iterative CORDIC, one rotation a cycle while step is high, giving
// cos/sin in Q2.30. Depends on mpoa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mpoa_cordic (
    input  wire logic                          clk,
    input  wire logic                          start,
    input  wire logic                          step,
    input  wire logic [mpoa_pkg::StepW-1:0]    step_idx,
    input  wire logic [31:0]                   turns,
    output logic signed [31:0]                 cos_val,
    output logic signed [31:0]                 sin_val
);

    logic signed [32:0] x_reg, y_reg;
    logic signed [33:0] z_reg;
    logic [1:0]         q_reg;
    logic [1:0]         q_next;
    logic [31:0]        rr;
    logic signed [32:0] dx, dy, xc, yc;
    logic signed [33:0] at;

    assign q_next = 2'((turns + 32'h2000_0000) >> 30);
    assign rr     = turns - {q_next, 30'd0};
    assign dx     = y_reg >>> step_idx;
    assign dy     = x_reg >>> step_idx;
    assign at     = 34'(mpoa_pkg::atan_turns(step_idx));

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= mpoa_pkg::CordicX0;
            y_reg <= '0;
            z_reg <= 34'(signed'(rr));
            q_reg <= q_next;
        end
        else if (step)
        begin
            if (!z_reg[33])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
    end

    always_comb
    begin
        xc = (x_reg > mpoa_pkg::One30) ? mpoa_pkg::One30 :
             (x_reg < -mpoa_pkg::One30) ? -mpoa_pkg::One30 : x_reg;
        yc = (y_reg > mpoa_pkg::One30) ? mpoa_pkg::One30 :
             (y_reg < -mpoa_pkg::One30) ? -mpoa_pkg::One30 : y_reg;
        case (q_reg)
            2'd0:    begin cos_val = 32'(xc);  sin_val = 32'(yc);  end
            2'd1:    begin cos_val = 32'(-yc); sin_val = 32'(xc);  end
            2'd2:    begin cos_val = 32'(-xc); sin_val = 32'(-yc); end
            default: begin cos_val = 32'(yc);  sin_val = 32'(-xc); end
        endcase
    end

endmodule
`default_nettype wire

[src/mpoa_datapath.sv]
// Datapath: request and config registers, angle multiply, phase tables,
// complex multiplier and accumulator store. Depends on mpoa_pkg, mpoa_cordic.
`timescale 1ns / 1ps
`default_nettype none
module mpoa_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire mpoa_pkg::in_word_t   in_word,
    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire mpoa_pkg::cmd_t       cmd,
    output mpoa_pkg::status_t         status,
    output mpoa_pkg::out_word_t       out_word
);

    localparam int AW = mpoa_pkg::AddrW;
    localparam int FW = mpoa_pkg::FreqW;

    logic [31:0]        inv_beta_reg;
    logic signed [10:0] first_row_reg, first_col_reg;
    mpoa_pkg::in_word_t req_reg;

    logic [31:0]        angle_reg;
    logic [31:0]        turns;
    logic signed [11:0] n0;
    logic signed [12:0] nsel;
    logic signed [31:0] cos_val, sin_val;

    logic signed [31:0] row_c [mpoa_pkg::NumFreq];
    logic signed [31:0] row_s [mpoa_pkg::NumFreq];
    logic signed [31:0] col_c [mpoa_pkg::NumFreq];
    logic signed [31:0] col_s [mpoa_pkg::NumFreq];

    logic signed [96:0] mem [mpoa_pkg::Depth];
    logic signed [96:0] rd_reg;

    // multiplier operands
    logic signed [33:0] ma_re, ma_im;
    logic signed [31:0] mb_re, mb_im;
    logic signed [65:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [33:0] a_re_reg, a_im_reg;
    logic signed [33:0] t_re, t_im;
    logic signed [49:0] s_re, s_im;
    logic signed [47:0] n_re, n_im;
    logic               hit;
    logic [FW-1:0]      fi;
    logic               mac_v_reg;
    logic [AW-1:0]      addr_d1_reg;

    function automatic logic signed [33:0] rnd30(input logic signed [65:0] v);
        logic signed [66:0] t;
        t = 67'(v) + 67'sd536870912;
        return 34'(t >>> 30);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_beta_reg  <= 32'd16777216;
            first_row_reg <= -11'sd16;
            first_col_reg <= -11'sd16;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mpoa_pkg::CFG_INV_BETA:  inv_beta_reg  <= cfg_data;
                mpoa_pkg::CFG_FIRST_ROW: first_row_reg <= cfg_data[10:0];
                mpoa_pkg::CFG_FIRST_COL: first_col_reg <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
            req_reg <= in_word;
    end

    // t/beta mod 2 in Q1.31
    always_ff @(posedge clk)
    begin
        if (cmd.angle_mul)
            angle_reg <= 32'(({32'd0, cmd.col_sel ? req_reg.time_col : req_reg.time_row}
                              * {32'd0, inv_beta_reg}) >> 17);
    end

    assign fi   = cmd.idx[FW-1:0];
    assign n0   = cmd.col_sel ? 12'(first_col_reg) : 12'(first_row_reg);
    assign nsel = 13'(n0) + 13'(signed'({1'b0, fi}));
    assign turns = angle_reg * 32'(signed'({nsel, 1'b1}));

    mpoa_cordic u_cordic (
        .clk      (clk),
        .start    (cmd.cordic_start),
        .step     (cmd.cordic_step),
        .step_idx (cmd.step),
        .turns    (turns),
        .cos_val  (cos_val),
        .sin_val  (sin_val)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.cordic_store)
        begin
            if (cmd.col_sel)
            begin
                col_c[fi] <= cos_val;
                col_s[fi] <= sin_val;
            end
            else
            begin
                row_c[fi] <= -cos_val;
                row_s[fi] <= sin_val;
            end
        end
    end

    // one complex multiply: weight x row phase, or a x col phase
    always_comb
    begin
        if (cmd.weight_mul)
        begin
            ma_re = 34'(req_reg.weight_re);
            ma_im = 34'(req_reg.weight_im);
            mb_re = row_c[fi];
            mb_im = row_s[fi];
        end
        else
        begin
            ma_re = a_re_reg;
            ma_im = a_im_reg;
            mb_re = col_c[fi];
            mb_im = col_s[fi];
        end
    end

    always_ff @(posedge clk)
    begin
        p_rr_reg <= ma_re * mb_re;
        p_ii_reg <= ma_im * mb_im;
        p_ri_reg <= ma_re * mb_im;
        p_ir_reg <= ma_im * mb_re;
    end

    // |a| reaches about 2^31.5, so a keeps 34 bits
    always_ff @(posedge clk)
    begin
        if (cmd.mac_rd && fi == '0 && cmd.step == 5'd1)
        begin
            a_re_reg <= rnd30(p_rr_reg) - rnd30(p_ii_reg);
            a_im_reg <= rnd30(p_ri_reg) + rnd30(p_ir_reg);
        end
    end

    assign t_re = rnd30(p_rr_reg) - rnd30(p_ii_reg);
    assign t_im = rnd30(p_ri_reg) + rnd30(p_ir_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mac_v_reg <= 1'b0;
        else
            mac_v_reg <= cmd.mac_rd && cmd.step == 5'd0;
    end

    always_ff @(posedge clk)
    begin
        addr_d1_reg <= cmd.addr;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mac_rd || cmd.read_rd)
            rd_reg <= mem[cmd.addr];
    end

    always_comb
    begin
        s_re = 50'(signed'(rd_reg[96:49])) + 50'(t_re);
        s_im = 50'(signed'(rd_reg[48:1])) + 50'(t_im);
        hit  = 1'b0;
        if (s_re > 50'(mpoa_pkg::AccMax))
        begin
            n_re = mpoa_pkg::AccMax; hit = 1'b1;
        end
        else if (s_re < 50'(mpoa_pkg::AccMin))
        begin
            n_re = mpoa_pkg::AccMin; hit = 1'b1;
        end
        else
            n_re = 48'(s_re);
        if (s_im > 50'(mpoa_pkg::AccMax))
        begin
            n_im = mpoa_pkg::AccMax; hit = 1'b1;
        end
        else if (s_im < 50'(mpoa_pkg::AccMin))
        begin
            n_im = mpoa_pkg::AccMin; hit = 1'b1;
        end
        else
            n_im = 48'(s_im);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
            mem[cmd.addr] <= '0;
        else if (cmd.mac_wr && mac_v_reg)
            mem[addr_d1_reg] <= {n_re, n_im, rd_reg[0] | hit};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (status.read_ok)
                out_word <= {rd_reg[96:49], rd_reg[48:1], rd_reg[0]};
            else
                out_word <= '0;
        end
    end

    assign status.req_type = req_reg.req_type;
    assign status.orb_ok   = 32'(req_reg.orbital_row) < 32'(mpoa_pkg::NumOrbitals)
                          && 32'(req_reg.orbital_col) < 32'(mpoa_pkg::NumOrbitals);
    assign status.read_ok  = status.orb_ok
                          && 32'(req_reg.freq_row) < 32'(mpoa_pkg::NumFreq)
                          && 32'(req_reg.freq_col) < 32'(mpoa_pkg::NumFreq);
    assign status.orow     = req_reg.orbital_row;
    assign status.ocol     = req_reg.orbital_col;

endmodule
`default_nettype wire

[src/mpoa_ctrl.sv]
// Controller: sequences clear sweep, phase generation, the multiply-accumulate
// sweep and reads. Depends on mpoa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mpoa_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire mpoa_pkg::status_t    status,
    input  wire logic [mpoa_pkg::FreqW-1:0] rd_frow,
    input  wire logic [mpoa_pkg::FreqW-1:0] rd_fcol,
    output mpoa_pkg::cmd_t            cmd
);

    localparam int AW = mpoa_pkg::AddrW;
    localparam int FW = mpoa_pkg::FreqW;

    mpoa_pkg::state_t state_reg, state_next;
    logic [AW:0]      cnt_reg, cnt_next;
    logic [FW:0]      idx_reg, idx_next;
    logic             col_reg, col_next;
    logic [mpoa_pkg::StepW-1:0] step_reg, step_next;
    logic             ov_reg, ov_next;
    logic [2*FW:0]    mac_cnt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mpoa_pkg::ST_CLEAR;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            col_reg   <= 1'b0;
            step_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            col_reg   <= col_next;
            step_reg  <= step_next;
            ov_reg    <= ov_next;
        end
    end

    assign mac_cnt = cnt_reg[2*FW:0];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        col_next   = col_reg;
        step_next  = step_reg;
        ov_next    = ov_reg && !out_ready;
        cmd        = '0;
        cmd.idx    = idx_reg;
        cmd.col_sel = col_reg;
        cmd.step   = step_reg;
        in_ready   = 1'b0;
        case (state_reg)
            mpoa_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load_req = in_valid;
                cnt_next = '0;
                idx_next = '0;
                col_next = 1'b0;
                // dispatch on the word after it is registered
                if (in_valid)
                    state_next = mpoa_pkg::ST_WEIGHT; // decode state reused
                step_next = '0;
            end
            mpoa_pkg::ST_WEIGHT:
            begin
                // decode
                case (status.req_type)
                    mpoa_pkg::REQ_CLEAR: state_next = mpoa_pkg::ST_CLEAR;
                    mpoa_pkg::REQ_ACCUM:
                        state_next = status.orb_ok ? mpoa_pkg::ST_ANGLE
                                                   : mpoa_pkg::ST_IDLE;
                    mpoa_pkg::REQ_READ:  state_next = mpoa_pkg::ST_READ;
                    default:             state_next = mpoa_pkg::ST_IDLE;
                endcase
            end
            mpoa_pkg::ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                cmd.addr     = cnt_reg[AW-1:0];
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg[AW-1:0] == '1)
                begin
                    cnt_next   = '0;
                    state_next = mpoa_pkg::ST_IDLE;
                end
            end
            mpoa_pkg::ST_ANGLE:
            begin
                cmd.angle_mul = 1'b1;
                idx_next      = '0;
                state_next    = mpoa_pkg::ST_CORDIC_START;
            end
            mpoa_pkg::ST_CORDIC_START:
            begin
                cmd.cordic_start = 1'b1;
                step_next        = '0;
                state_next       = mpoa_pkg::ST_CORDIC_RUN;
            end
            mpoa_pkg::ST_CORDIC_RUN:
            begin
                if (32'(step_reg) == mpoa_pkg::CordicSteps)
                begin
                    cmd.cordic_store = 1'b1;
                    step_next        = '0;
                    idx_next         = idx_reg + 1'b1;
                    if (32'(idx_reg) == mpoa_pkg::NumFreq - 1)
                    begin
                        idx_next = '0;
                        if (col_reg)
                        begin
                            col_next   = 1'b0;
                            cnt_next   = '0;
                            state_next = mpoa_pkg::ST_MAC;
                        end
                        else
                        begin
                            col_next   = 1'b1;
                            state_next = mpoa_pkg::ST_ANGLE;
                        end
                    end
                    else
                        state_next = mpoa_pkg::ST_CORDIC_START;
                end
                else
                begin
                    cmd.cordic_step = 1'b1;
                    step_next       = step_reg + 1'b1;
                end
            end
            mpoa_pkg::ST_MAC:
            begin
                // per row: step 0 weight multiply, step 1 capture a, then 32
                // column multiplies, each written in the cycle after its read
                cmd.addr = {status.orow, status.ocol, idx_reg[FW-1:0], cnt_reg[FW-1:0]};
                if (step_reg == 5'd0)
                begin
                    cmd.weight_mul = 1'b1;
                    step_next      = 5'd1;
                end
                else if (step_reg == 5'd1)
                begin
                    cmd.mac_rd = 1'b1;
                    cmd.idx    = '0;
                    step_next  = 5'd2;
                    cnt_next   = '0;
                end
                else
                begin
                    // step 2: column sweep, then a drain of the trailing write
                    cmd.idx    = {1'b0, cnt_reg[FW-1:0]};
                    cmd.mac_rd = (32'(cnt_reg) < mpoa_pkg::NumFreq);
                    cmd.step   = '0;
                    cmd.mac_wr = 1'b1;
                    cnt_next   = cnt_reg + 1'b1;
                    if (32'(cnt_reg) == mpoa_pkg::NumFreq + 1)
                    begin
                        step_next = '0;
                        cnt_next  = '0;
                        idx_next  = idx_reg + 1'b1;
                        if (32'(idx_reg) == mpoa_pkg::NumFreq - 1)
                        begin
                            idx_next   = '0;
                            state_next = mpoa_pkg::ST_IDLE;
                        end
                    end
                end
                if (step_reg == 5'd0)
                    cmd.idx = idx_reg;
            end
            mpoa_pkg::ST_READ:
            begin
                cmd.read_rd = 1'b1;
                cmd.addr    = {status.orow, status.ocol, rd_frow, rd_fcol};
                state_next  = mpoa_pkg::ST_READ_WAIT;
            end
            mpoa_pkg::ST_READ_WAIT:
            begin
                // hold until the output register is free
                if (!ov_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = mpoa_pkg::ST_IDLE;
                end
            end
            default:
                state_next = mpoa_pkg::ST_IDLE;
        endcase
        out_valid = ov_reg;
    end

    unused_mac_cnt_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mpoa_pkg::ST_MAC) |-> (mac_cnt <= (2*FW+1)'(mpoa_pkg::NumFreq + 1)))
        else $error("column counter overrun");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped before it was taken");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_wr |-> !cmd.mac_wr)
        else $error("clear and accumulate write together");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mpoa_pkg::ST_READ_WAIT) |=> out_valid)
        else $error("read result not presented");

endmodule
`default_nettype wire

[src/matsubara_phase_outer_accumulator.sv]
// Top level of the Matsubara phase outer accumulator.
// Depends on mpoa_pkg, mpoa_ctrl, mpoa_datapath.
//
// Channels: in (valid/ready, in_word_t word), out (valid/ready, out_word_t
// word), cfg (valid/ready, register index and 32-bit data, always ready).
// A clear word sweeps the 16384-entry store, one entry a cycle.
// An accumulate word first builds 64 phases on one iterative CORDIC, with
// one angle multiply per side; then 32 rows go through the one complex
// multiplier. A read word is decoded, reads the store, and then loads the
// output register once that register is free.
// One word is worked on at a time.
// After reset the same clearing pass runs with in_ready low;
// configuration writes are taken throughout.
// A pending result is held in the output register until taken; input words
// are still taken meanwhile, and a following read waits for the register.
`timescale 1ns / 1ps
`default_nettype none
module matsubara_phase_outer_accumulator (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire mpoa_pkg::in_word_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output mpoa_pkg::out_word_t      out_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [31:0]         cfg_data
);

    mpoa_pkg::cmd_t    cmd;
    mpoa_pkg::status_t status;
    mpoa_pkg::in_word_t req_shadow;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            req_shadow <= in_data;
    end

    mpoa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .rd_frow   (req_shadow.freq_row),
        .rd_fcol   (req_shadow.freq_col),
        .cmd       (cmd)
    );

    mpoa_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_data),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_word  (out_data)
    );

endmodule
`default_nettype wire

[test/testbench.sv]
// Testbench for matsubara_phase_outer_accumulator: directed and random words,
// a predictor of the phase outer-product store, and a scoreboard on reads.
// Depends on mpoa_pkg and the RTL top level.
`timescale 1ns / 1ps
module testbench;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    mpoa_pkg::in_word_t  in_data;
    logic      out_valid;
    logic      out_ready;
    mpoa_pkg::out_word_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    matsubara_phase_outer_accumulator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    localparam longint Unit30 = 64'sd1073741824;
    localparam longint Top48  = 64'sd140737488355327;
    localparam longint Bot48  = -64'sd140737488355328;
    localparam longint ArcTurn [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    // predictor state
    logic [31:0]        inv_beta;
    logic signed [10:0] n_row;
    logic signed [10:0] n_col;
    longint sum_re [16384];
    longint sum_im [16384];
    bit     sum_sat [16384];
    longint row_cos [32];
    longint row_sin [32];
    longint col_cos [32];
    longint col_sin [32];

    mpoa_pkg::out_word_t read_q[$];
    int        errors;
    int        burst_left;
    logic [1:0] hot_orow;
    logic [1:0] hot_ocol;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #300ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic longint round30(input longint v);
        return (v + (Unit30 >>> 1)) >>> 30;
    endfunction

    function automatic longint clamp_unit(input longint v);
        if (v > Unit30) return Unit30;
        if (v < -Unit30) return -Unit30;
        return v;
    endfunction

    function automatic void cordic_phase(input logic [31:0] turns,
                                         output longint c, output longint s);
        logic [31:0] shifted;
        logic [31:0] rem;
        logic [1:0]  quad;
        longint x, y, z, dx, dy;
        shifted = turns + 32'h2000_0000;
        quad = shifted[31:30];
        rem = turns - {quad, 30'd0};
        z = longint'(signed'(rem));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 30; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= ArcTurn[i];
            end
            else
            begin
                x += dx; y -= dy; z += ArcTurn[i];
            end
        end
        x = clamp_unit(x);
        y = clamp_unit(y);
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic void build_phases(input logic [31:0] t, input logic signed [10:0] n0,
                                         input bit col_side);
        logic [63:0] prod;
        logic [31:0] frac;
        logic [31:0] odd;
        longint c, s, n;
        prod = 64'(t) * 64'(inv_beta);
        frac = prod[48:17];
        for (int i = 0; i < 32; i++)
        begin
            n = longint'(n0) + i;
            odd = 32'(2 * n + 1);
            cordic_phase(frac * odd, c, s);
            if (col_side)
            begin
                col_cos[i] = c; col_sin[i] = s;
            end
            else
            begin
                row_cos[i] = c; row_sin[i] = s;
            end
        end
    endfunction

    function automatic void clear_store();
        for (int k = 0; k < 16384; k++)
        begin
            sum_re[k] = 0; sum_im[k] = 0; sum_sat[k] = 0;
        end
    endfunction

    function automatic void accumulate_phases(input mpoa_pkg::in_word_t w);
        longint wr, wi, pr, pi, ar, ai, tr, ti, nr, ni;
        int k;
        bit hit;
        wr = longint'(w.weight_re);
        wi = longint'(w.weight_im);
        build_phases(w.time_row, n_row, 1'b0);
        build_phases(w.time_col, n_col, 1'b1);
        for (int i1 = 0; i1 < 32; i1++)
        begin
            pr = -row_cos[i1];
            pi = row_sin[i1];
            ar = round30(wr * pr) - round30(wi * pi);
            ai = round30(wr * pi) + round30(wi * pr);
            for (int i2 = 0; i2 < 32; i2++)
            begin
                tr = round30(ar * col_cos[i2]) - round30(ai * col_sin[i2]);
                ti = round30(ar * col_sin[i2]) + round30(ai * col_cos[i2]);
                k = ((int'(w.orbital_row) * 4 + int'(w.orbital_col)) * 32 + i1) * 32 + i2;
                hit = 1'b0;
                nr = sum_re[k] + tr;
                ni = sum_im[k] + ti;
                if (nr > Top48) begin nr = Top48; hit = 1'b1; end
                if (nr < Bot48) begin nr = Bot48; hit = 1'b1; end
                if (ni > Top48) begin ni = Top48; hit = 1'b1; end
                if (ni < Bot48) begin ni = Bot48; hit = 1'b1; end
                sum_re[k] = nr;
                sum_im[k] = ni;
                if (hit) sum_sat[k] = 1'b1;
            end
        end
    endfunction

    function automatic void predict_word(input mpoa_pkg::in_word_t w);
        mpoa_pkg::out_word_t r;
        int k;
        case (mpoa_pkg::req_t'(w.req_type))
            mpoa_pkg::REQ_CLEAR: clear_store();
            mpoa_pkg::REQ_ACCUM: accumulate_phases(w);
            mpoa_pkg::REQ_READ:
            begin
                k = ((int'(w.orbital_row) * 4 + int'(w.orbital_col)) * 32
                     + int'(w.freq_row)) * 32 + int'(w.freq_col);
                r.value_re = sum_re[k][47:0];
                r.value_im = sum_im[k][47:0];
                r.saturated_flag = sum_sat[k];
                read_q = {read_q, r};
            end
            default: ;
        endcase
    endfunction

    // result scoreboard
    always @(posedge clk)
    begin
        mpoa_pkg::out_word_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (read_q.size() == 0)
            begin
                $display("%0t unexpected result re=%0d im=%0d", $time,
                         out_data.value_re, out_data.value_im);
                errors++;
            end
            else
            begin
                e = read_q.pop_front();
                if (out_data.value_re !== e.value_re)
                begin
                    $display("%0t value_re exp %0d got %0d", $time, e.value_re,
                             out_data.value_re);
                    errors++;
                end
                if (out_data.value_im !== e.value_im)
                begin
                    $display("%0t value_im exp %0d got %0d", $time, e.value_im,
                             out_data.value_im);
                    errors++;
                end
                if (out_data.saturated_flag !== e.saturated_flag)
                begin
                    $display("%0t saturated_flag exp %0b got %0b", $time,
                             e.saturated_flag, out_data.saturated_flag);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern: randomly chosen calm and stalling stretches
    int  stall_cnt;
    bit  stall_on;
    always @(posedge clk)
    begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt[5:0] == 6'd0) stall_on <= ($urandom_range(0, 2) == 0);
        if (stall_on) out_ready <= ($urandom_range(0, 3) == 0);
        else out_ready <= 1'b1;
    end

    task automatic send_word(input mpoa_pkg::in_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data <= w;
        do @(posedge clk); while (!in_ready);
        predict_word(w);
    endtask

    task automatic write_reg(input mpoa_pkg::cfg_idx_t idx, input logic [31:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            mpoa_pkg::CFG_INV_BETA:  inv_beta = d;
            mpoa_pkg::CFG_FIRST_ROW: n_row = d[10:0];
            mpoa_pkg::CFG_FIRST_COL: n_col = d[10:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (read_q.size() != 0) @(posedge clk);
        repeat (17000) @(posedge clk);
    endtask

    function automatic mpoa_pkg::in_word_t rand_word(input mpoa_pkg::req_t req);
        mpoa_pkg::in_word_t w;
        w.req_type = req;
        w.time_row = $urandom;
        w.time_col = $urandom;
        w.orbital_row = 2'($urandom_range(0, 3));
        w.orbital_col = 2'($urandom_range(0, 3));
        w.weight_re = $urandom;
        w.weight_im = $urandom;
        w.freq_row = 5'($urandom_range(0, 31));
        w.freq_col = 5'($urandom_range(0, 31));
        return w;
    endfunction

    function automatic mpoa_pkg::in_word_t accum_word(input logic [31:0] tr,
                                                      input logic [31:0] tc,
                                                      input logic [1:0] orow,
                                                      input logic [1:0] ocol,
                                                      input logic [31:0] wr,
                                                      input logic [31:0] wi);
        mpoa_pkg::in_word_t w;
        w = rand_word(mpoa_pkg::REQ_ACCUM);
        w.time_row = tr;
        w.time_col = tc;
        w.orbital_row = orow;
        w.orbital_col = ocol;
        w.weight_re = wr;
        w.weight_im = wi;
        return w;
    endfunction

    function automatic mpoa_pkg::in_word_t read_word(input logic [1:0] orow,
                                                     input logic [1:0] ocol,
                                                     input logic [4:0] fr,
                                                     input logic [4:0] fc);
        mpoa_pkg::in_word_t w;
        w = rand_word(mpoa_pkg::REQ_READ);
        w.orbital_row = orow;
        w.orbital_col = ocol;
        w.freq_row = fr;
        w.freq_col = fc;
        return w;
    endfunction

    task automatic test_reset_state();
        send_word(read_word(2'd0, 2'd0, 5'd0, 5'd0));
        send_word(read_word(2'd3, 2'd3, 5'd31, 5'd31));
    endtask

    task automatic test_extremes();
        send_word(accum_word(32'd0, 32'd0, 2'd0, 2'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_word(accum_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 2'd3,
                             32'h8000_0000, 32'h8000_0000));
        send_word(accum_word(32'h0100_0000, 32'h0080_0000, 2'd0, 2'd0,
                             32'h4000_0000, 32'h0000_0000));
        send_word(accum_word(32'h0040_0000, 32'h00C0_0000, 2'd3, 2'd3,
                             32'h8000_0000, 32'h7FFF_FFFF));
        send_word(read_word(2'd0, 2'd0, 5'd0, 5'd0));
        send_word(read_word(2'd0, 2'd0, 5'd31, 5'd31));
        send_word(read_word(2'd0, 2'd0, 5'd17, 5'd3));
        send_word(read_word(2'd3, 2'd3, 5'd0, 5'd31));
        send_word(read_word(2'd3, 2'd3, 5'd31, 5'd0));
        // unused code: no result, store untouched
        send_word(rand_word(mpoa_pkg::REQ_NONE));
        send_word(read_word(2'd3, 2'd3, 5'd5, 5'd9));
        send_word(rand_word(mpoa_pkg::REQ_CLEAR));
        send_word(read_word(2'd0, 2'd0, 5'd0, 5'd0));
        send_word(read_word(2'd3, 2'd3, 5'd31, 5'd31));
    endtask

    task automatic test_config_settings();
        logic [31:0] betas [4] = '{32'd0, 32'hFFFF_FFFF, 32'h0040_0000, 32'h0300_0000};
        logic [10:0] rows [4] = '{11'h400, 11'h3FF, 11'h000, 11'h7F0};
        logic [10:0] cols [4] = '{11'h3FF, 11'h400, 11'h7FF, 11'h010};
        for (int p = 0; p < 4; p++)
        begin
            drain();
            write_reg(mpoa_pkg::CFG_INV_BETA, betas[p]);
            write_reg(mpoa_pkg::CFG_FIRST_ROW, {21'd0, rows[p]});
            write_reg(mpoa_pkg::CFG_FIRST_COL, {21'd0, cols[p]});
            send_word(accum_word($urandom, $urandom, 2'd1, 2'd2, $urandom, $urandom));
            send_word(read_word(2'd1, 2'd2, 5'($urandom_range(0, 31)),
                                5'($urandom_range(0, 31))));
            send_word(read_word(2'd1, 2'd2, 5'd0, 5'd31));
        end
        drain();
        write_reg(mpoa_pkg::CFG_INV_BETA, 32'h0100_0000);
        write_reg(mpoa_pkg::CFG_FIRST_ROW, 32'h0000_07F0);
        write_reg(mpoa_pkg::CFG_FIRST_COL, 32'h0000_07F0);
    endtask

    task automatic test_random();
        int r;
        mpoa_pkg::in_word_t w;
        hot_orow = 2'd1;
        hot_ocol = 2'd2;
        for (int n = 0; n < 400; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 2)
            begin
                w = rand_word(mpoa_pkg::REQ_CLEAR);
            end
            else if (r < 16)
            begin
                w = rand_word(mpoa_pkg::REQ_ACCUM);
                if ($urandom_range(0, 3) != 0)
                begin
                    w.orbital_row = hot_orow;
                    w.orbital_col = hot_ocol;
                end
                if ($urandom_range(0, 1) == 0)
                begin
                    w.time_row = $urandom_range(0, 32'h0100_0000);
                    w.time_col = $urandom_range(0, 32'h0100_0000);
                end
                hot_orow = w.orbital_row;
                hot_ocol = w.orbital_col;
            end
            else if (r < 20)
            begin
                w = rand_word(mpoa_pkg::REQ_NONE);
            end
            else
            begin
                w = rand_word(mpoa_pkg::REQ_READ);
                if ($urandom_range(0, 9) < 7)
                begin
                    w.orbital_row = hot_orow;
                    w.orbital_col = hot_ocol;
                end
            end
            send_word(w);
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        errors = 0;
        burst_left = 0;
        stall_cnt = 0;
        stall_on = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b1;
        cfg_valid = 1'b0;
        cfg_index = mpoa_pkg::CFG_INV_BETA;
        cfg_data = '0;
        inv_beta = 32'h0100_0000;
        n_row = -11'sd16;
        n_col = -11'sd16;
        clear_store();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_extremes();
        test_config_settings();
        test_random();
        while (read_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[matsubara_phase_outer_accumulator.f]
src/mpoa_pkg.sv
src/mpoa_cordic.sv
src/mpoa_datapath.sv
src/mpoa_ctrl.sv
src/matsubara_phase_outer_accumulator.sv
test/testbench.sv
